@@ rtl/core/nmea_rmc_position_extractor_top_assert.svh @@
// Assertion macros for the NMEA RMC position extractor checker.
// Included by the checker file only; no other dependencies.
`ifndef NMEA_RMC_POSITION_EXTRACTOR_TOP_ASSERT_SVH
`define NMEA_RMC_POSITION_EXTRACTOR_TOP_ASSERT_SVH

// same-cycle implication, disabled in reset
`define NRPE_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define NRPE_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/nrpe_pkg.sv @@
// Shared constants for the NMEA RMC position extractor.
// No dependencies; imported by the parser, emitter and top level.
`timescale 1ns / 1ps

package nrpe_pkg;

    localparam int TAG_W     = 48;
    localparam int CFG_AW    = 5;
    localparam int CFG_DW    = 64;

    localparam logic [TAG_W-1:0] TAG_RESET     = 48'h24474E524D43;  // "$GNRMC"
    localparam logic [7:0]       MAX_LEN_RESET = 8'd150;
    localparam logic [3:0]       LAT_NUM_RESET = 4'd4;
    localparam logic [3:0]       LON_NUM_RESET = 4'd6;

    localparam logic [7:0] ASCII_STAR  = 8'h2A;
    localparam logic [7:0] ASCII_COMMA = 8'h2C;

    localparam logic [2:0] TAG_LEN    = 3'd6;
    localparam logic [7:0] SPAN_START = 8'd5;
    localparam logic [8:0] TRAILER    = 9'd3;
    localparam logic [7:0] CNT_MAX    = 8'd255;

    // register indexes (byte address = 8 * index)
    localparam logic [1:0] REG_TAG     = 2'd0;
    localparam logic [1:0] REG_MAX_LEN = 2'd1;
    localparam logic [1:0] REG_LAT_NUM = 2'd2;
    localparam logic [1:0] REG_LON_NUM = 2'd3;

    typedef struct packed {
        logic [TAG_W-1:0] sentence_tag;
        logic [7:0]       max_length;
        logic [3:0]       lat_field_number;
        logic [3:0]       lon_field_number;
    } cfg_t;

endpackage

@@ rtl/core/nrpe_char_mem.sv @@
// Character store: one write port, one read port, registered read data.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps

module nrpe_char_mem #(
    parameter int DEPTH = 9,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0] mem [0:DEPTH-1];
    logic [7:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/core/nrpe_parser.sv @@
// Byte intake: tag hunt, field and span counting, character store writes.
// Depends on nrpe_pkg.
`timescale 1ns / 1ps

module nrpe_parser
    import nrpe_pkg::*;
#(
    parameter int LAT_CHARS = 9,
    parameter int LON_CHARS = 10,
    parameter int LAT_AW    = (LAT_CHARS > 1) ? $clog2(LAT_CHARS) : 1,
    parameter int LON_AW    = (LON_CHARS > 1) ? $clog2(LON_CHARS) : 1,
    parameter int LAT_LW    = $clog2(LAT_CHARS + 1),
    parameter int LON_LW    = $clog2(LON_CHARS + 1)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  cfg_t              cfg,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [7:0]        s_rx_byte,
    output logic              lat_wr_en,
    output logic [LAT_AW-1:0] lat_wr_addr,
    output logic              lon_wr_en,
    output logic [LON_AW-1:0] lon_wr_addr,
    output logic [LAT_LW-1:0] lat_len,
    output logic [LON_LW-1:0] lon_len,
    output logic              emit_start,
    input  logic              emit_done
);

    logic [2:0]        match_phase_reg, match_phase_next;
    logic              in_sent_reg, in_sent_next;
    logic [7:0]        field_cnt_reg, field_cnt_next;
    logic [7:0]        span_reg, span_next;
    logic [LAT_LW-1:0] lat_len_reg, lat_len_next;
    logic [LON_LW-1:0] lon_len_reg, lon_len_next;
    logic              busy_reg, busy_next;

    logic       accept;
    logic [7:0] tag_byte;
    logic [7:0] span_inc;
    logic       len_ok;
    logic       is_data;

    assign s_ready = aresetn && !busy_reg;
    assign accept  = s_valid && s_ready;

    always_comb begin
        unique case (match_phase_reg)
            3'd0:    tag_byte = cfg.sentence_tag[47:40];
            3'd1:    tag_byte = cfg.sentence_tag[39:32];
            3'd2:    tag_byte = cfg.sentence_tag[31:24];
            3'd3:    tag_byte = cfg.sentence_tag[23:16];
            3'd4:    tag_byte = cfg.sentence_tag[15:8];
            3'd5:    tag_byte = cfg.sentence_tag[7:0];
            default: tag_byte = cfg.sentence_tag[47:40];
        endcase
    end

    assign span_inc = (span_reg < CNT_MAX) ? span_reg + 8'd1 : span_reg;
    assign len_ok   = ({1'b0, span_inc} + TRAILER) < {1'b0, cfg.max_length};
    assign is_data  = accept && in_sent_reg && (s_rx_byte != ASCII_STAR)
                      && (s_rx_byte != ASCII_COMMA);

    assign lat_wr_en   = is_data && (field_cnt_reg == {4'd0, cfg.lat_field_number})
                         && (lat_len_reg < LAT_LW'(LAT_CHARS));
    assign lon_wr_en   = is_data && (field_cnt_reg == {4'd0, cfg.lon_field_number})
                         && (lon_len_reg < LON_LW'(LON_CHARS));
    assign lat_wr_addr = LAT_AW'(lat_len_reg);
    assign lon_wr_addr = LON_AW'(lon_len_reg);
    assign lat_len     = lat_len_reg;
    assign lon_len     = lon_len_reg;

    assign emit_start = accept && in_sent_reg && (s_rx_byte == ASCII_STAR) && len_ok;

    always_comb begin
        match_phase_next = match_phase_reg;
        in_sent_next     = in_sent_reg;
        field_cnt_next   = field_cnt_reg;
        span_next        = span_reg;
        lat_len_next     = lat_len_reg;
        lon_len_next     = lon_len_reg;
        busy_next        = busy_reg;

        if (emit_done) begin
            busy_next = 1'b0;
        end

        if (accept && !in_sent_reg) begin
            if (s_rx_byte == tag_byte) begin
                match_phase_next = match_phase_reg + 3'd1;
            end else begin
                match_phase_next = (s_rx_byte == cfg.sentence_tag[47:40]) ? 3'd1 : 3'd0;
            end
            if (match_phase_next == TAG_LEN) begin
                match_phase_next = 3'd0;
                in_sent_next     = 1'b1;
                field_cnt_next   = 8'd1;
                span_next        = SPAN_START;
                lat_len_next     = '0;
                lon_len_next     = '0;
            end
        end else if (accept) begin
            span_next = span_inc;
            if (s_rx_byte == ASCII_STAR) begin
                // sentence ends; lengths stay put for the emitter
                in_sent_next   = 1'b0;
                field_cnt_next = 8'd0;
                span_next      = 8'd0;
                busy_next      = len_ok;
            end else if (s_rx_byte == ASCII_COMMA) begin
                if (field_cnt_reg < CNT_MAX) begin
                    field_cnt_next = field_cnt_reg + 8'd1;
                end
            end else begin
                if (lat_wr_en) begin
                    lat_len_next = lat_len_reg + LAT_LW'(1);
                end
                if (lon_wr_en) begin
                    lon_len_next = lon_len_reg + LON_LW'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            match_phase_reg <= 3'd0;
            in_sent_reg     <= 1'b0;
            field_cnt_reg   <= 8'd0;
            span_reg        <= 8'd0;
            lat_len_reg     <= '0;
            lon_len_reg     <= '0;
            busy_reg        <= 1'b0;
        end else begin
            match_phase_reg <= match_phase_next;
            in_sent_reg     <= in_sent_next;
            field_cnt_reg   <= field_cnt_next;
            span_reg        <= span_next;
            lat_len_reg     <= lat_len_next;
            lon_len_reg     <= lon_len_next;
            busy_reg        <= busy_next;
        end
    end

endmodule

@@ rtl/core/nrpe_emitter.sv @@
// Result sequencer: reads the character stores and drives the output register.
// Depends on nrpe_pkg.
`timescale 1ns / 1ps

module nrpe_emitter
    import nrpe_pkg::*;
#(
    parameter int LAT_CHARS = 9,
    parameter int LON_CHARS = 10,
    parameter int LAT_AW    = (LAT_CHARS > 1) ? $clog2(LAT_CHARS) : 1,
    parameter int LON_AW    = (LON_CHARS > 1) ? $clog2(LON_CHARS) : 1,
    parameter int LAT_LW    = $clog2(LAT_CHARS + 1),
    parameter int LON_LW    = $clog2(LON_CHARS + 1),
    parameter int LEN_W     = (LAT_LW > LON_LW) ? LAT_LW : LON_LW
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              emit_start,
    output logic              emit_done,
    input  logic [LAT_LW-1:0] lat_len,
    input  logic [LON_LW-1:0] lon_len,
    output logic [LAT_AW-1:0] lat_rd_addr,
    input  logic [7:0]        lat_rd_data,
    output logic [LON_AW-1:0] lon_rd_addr,
    input  logic [7:0]        lon_rd_data,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_field_sel,
    output logic [3:0]        m_char_pos,
    output logic [7:0]        m_char_value,
    output logic [3:0]        m_field_length,
    output logic              m_last
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_LOAD = 2'd2;
    localparam logic [1:0] ST_HOLD = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic             sel_reg, sel_next;
    logic [LEN_W-1:0] idx_reg, idx_next;
    logic             valid_reg, valid_next;
    logic [3:0]       pos_reg;
    logic [7:0]       char_reg;
    logic [3:0]       flen_reg;
    logic             last_reg;

    logic [LEN_W-1:0] cur_len;
    logic             field_end;
    logic             cur_last;

    assign cur_len   = sel_reg ? LEN_W'(lon_len) : LEN_W'(lat_len);
    assign field_end = (cur_len == '0) || (idx_reg + LEN_W'(1) == cur_len);
    assign cur_last  = sel_reg && field_end;

    assign lat_rd_addr = LAT_AW'(idx_reg);
    assign lon_rd_addr = LON_AW'(idx_reg);

    assign emit_done = (state_reg == ST_HOLD) && m_ready && last_reg;

    always_comb begin
        state_next = state_reg;
        sel_next   = sel_reg;
        idx_next   = idx_reg;
        valid_next = valid_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (emit_start) begin
                    state_next = ST_READ;
                    sel_next   = 1'b0;
                    idx_next   = '0;
                end
            end
            ST_READ: begin
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                state_next = ST_HOLD;
                valid_next = 1'b1;
            end
            ST_HOLD: begin
                if (m_ready) begin
                    valid_next = 1'b0;
                    if (last_reg) begin
                        state_next = ST_IDLE;
                    end else if (field_end) begin
                        state_next = ST_READ;
                        sel_next   = 1'b1;
                        idx_next   = '0;
                    end else begin
                        state_next = ST_READ;
                        idx_next   = idx_reg + LEN_W'(1);
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        sel_reg <= sel_next;
        idx_reg <= idx_next;
        if (state_reg == ST_LOAD) begin
            pos_reg  <= 4'(idx_reg);
            flen_reg <= 4'(cur_len);
            last_reg <= cur_last;
            if (cur_len == '0) begin
                char_reg <= 8'd0;
            end else begin
                char_reg <= sel_reg ? lon_rd_data : lat_rd_data;
            end
        end
    end

    assign m_valid        = valid_reg;
    assign m_field_sel    = sel_reg;
    assign m_char_pos     = pos_reg;
    assign m_char_value   = char_reg;
    assign m_field_length = flen_reg;
    assign m_last         = last_reg;

endmodule

@@ rtl/core/nmea_rmc_position_extractor_top.sv @@
// Top level of the NMEA RMC position extractor: APB registers and block wiring.
// Depends on nrpe_pkg, nrpe_parser, nrpe_char_mem, nrpe_emitter.
//
//  port group   dir  handshake          payload
//  s_*          in   s_valid / s_ready  s_rx_byte
//  m_*          out  m_valid / m_ready  field_sel, char_pos, char_value, field_length, last
//  APB          in   psel & penable     paddr, pwdata, prdata (64-bit, reg i at 8*i)
//
// One byte per cycle is taken while hunting for the tag and inside a sentence.
// A '*' that closes a good sentence holds s_ready low until its last result leaves.
// Each result passes through a store read, an output load and a handshake that waits on m_ready.
// Reset is synchronous; the stores and the emitter's index and output data registers are not cleared.
`timescale 1ns / 1ps

module nmea_rmc_position_extractor_top
    import nrpe_pkg::*;
#(
    parameter int LAT_CHARS = 9,
    parameter int LON_CHARS = 10
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [CFG_DW-1:0] pwdata,
    output logic [CFG_DW-1:0] prdata,
    output logic              pready,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [7:0]        s_rx_byte,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_field_sel,
    output logic [3:0]        m_char_pos,
    output logic [7:0]        m_char_value,
    output logic [3:0]        m_field_length,
    output logic              m_last
);

    localparam int LAT_AW = (LAT_CHARS > 1) ? $clog2(LAT_CHARS) : 1;
    localparam int LON_AW = (LON_CHARS > 1) ? $clog2(LON_CHARS) : 1;
    localparam int LAT_LW = $clog2(LAT_CHARS + 1);
    localparam int LON_LW = $clog2(LON_CHARS + 1);

    cfg_t       cfg_reg;
    logic       cfg_wr;
    logic [1:0] reg_idx;

    logic              lat_wr_en, lon_wr_en;
    logic [LAT_AW-1:0] lat_wr_addr, lat_rd_addr;
    logic [LON_AW-1:0] lon_wr_addr, lon_rd_addr;
    logic [7:0]        lat_rd_data, lon_rd_data;
    logic [LAT_LW-1:0] lat_len;
    logic [LON_LW-1:0] lon_len;
    logic              emit_start, emit_done;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:3];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sentence_tag     <= TAG_RESET;
            cfg_reg.max_length       <= MAX_LEN_RESET;
            cfg_reg.lat_field_number <= LAT_NUM_RESET;
            cfg_reg.lon_field_number <= LON_NUM_RESET;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_TAG:     cfg_reg.sentence_tag     <= pwdata[TAG_W-1:0];
                REG_MAX_LEN: cfg_reg.max_length       <= pwdata[7:0];
                REG_LAT_NUM: cfg_reg.lat_field_number <= pwdata[3:0];
                REG_LON_NUM: cfg_reg.lon_field_number <= pwdata[3:0];
                default:     ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_TAG:     prdata = {16'd0, cfg_reg.sentence_tag};
            REG_MAX_LEN: prdata = {56'd0, cfg_reg.max_length};
            REG_LAT_NUM: prdata = {60'd0, cfg_reg.lat_field_number};
            REG_LON_NUM: prdata = {60'd0, cfg_reg.lon_field_number};
            default:     prdata = '0;
        endcase
    end

    nrpe_parser #(
        .LAT_CHARS (LAT_CHARS),
        .LON_CHARS (LON_CHARS)
    ) u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_rx_byte   (s_rx_byte),
        .lat_wr_en   (lat_wr_en),
        .lat_wr_addr (lat_wr_addr),
        .lon_wr_en   (lon_wr_en),
        .lon_wr_addr (lon_wr_addr),
        .lat_len     (lat_len),
        .lon_len     (lon_len),
        .emit_start  (emit_start),
        .emit_done   (emit_done)
    );

    nrpe_char_mem #(
        .DEPTH (LAT_CHARS)
    ) u_lat_mem (
        .aclk    (aclk),
        .wr_en   (lat_wr_en),
        .wr_addr (lat_wr_addr),
        .wr_data (s_rx_byte),
        .rd_addr (lat_rd_addr),
        .rd_data (lat_rd_data)
    );

    nrpe_char_mem #(
        .DEPTH (LON_CHARS)
    ) u_lon_mem (
        .aclk    (aclk),
        .wr_en   (lon_wr_en),
        .wr_addr (lon_wr_addr),
        .wr_data (s_rx_byte),
        .rd_addr (lon_rd_addr),
        .rd_data (lon_rd_data)
    );

    nrpe_emitter #(
        .LAT_CHARS (LAT_CHARS),
        .LON_CHARS (LON_CHARS)
    ) u_emitter (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .emit_start     (emit_start),
        .emit_done      (emit_done),
        .lat_len        (lat_len),
        .lon_len        (lon_len),
        .lat_rd_addr    (lat_rd_addr),
        .lat_rd_data    (lat_rd_data),
        .lon_rd_addr    (lon_rd_addr),
        .lon_rd_data    (lon_rd_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_field_sel    (m_field_sel),
        .m_char_pos     (m_char_pos),
        .m_char_value   (m_char_value),
        .m_field_length (m_field_length),
        .m_last         (m_last)
    );

endmodule

@@ rtl/core/nrpe_checker.sv @@
// Port-level checker for the NMEA RMC position extractor, bound to the top level.
// Depends on nmea_rmc_position_extractor_top_assert.svh.
`timescale 1ns / 1ps
`include "nmea_rmc_position_extractor_top_assert.svh"

module nrpe_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_field_sel,
    input logic [3:0] m_char_pos,
    input logic [7:0] m_char_value,
    input logic [3:0] m_field_length,
    input logic       m_last
);

    // no byte intake while results of a sentence are out
    `NRPE_ASSERT_SAME(a_no_intake_emit, aclk, aresetn, m_valid, !s_ready, "s_ready high during emit")

    // the final beat is always a longitude beat
    `NRPE_ASSERT_SAME(a_last_is_lon, aclk, aresetn, m_valid && m_last, m_field_sel, "last on lat beat")

    // a sentence's last beat leaves the output empty
    `NRPE_ASSERT_NEXT(a_gap_after_last, aclk, aresetn, m_valid && m_ready && m_last, !m_valid, "beat after last")

    `NRPE_ASSERT_NEXT(a_hold_stall, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_char_value) && $stable(m_char_pos) && $stable(m_field_length) && $stable(m_field_sel) && $stable(m_last), "stalled beat changed")

endmodule

bind nmea_rmc_position_extractor_top nrpe_checker u_nrpe_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_field_sel    (m_field_sel),
    .m_char_pos     (m_char_pos),
    .m_char_value   (m_char_value),
    .m_field_length (m_field_length),
    .m_last         (m_last)
);
